FILE: hw/rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/fsc_pkg.sv
package fsc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PLANE_COUNT    = 5;

  typedef enum logic [1:0] {
    OP_LOAD_CAM = 2'd0,
    OP_BUILD    = 2'd1,
    OP_LOAD_WLD = 2'd2,
    OP_TEST     = 2'd3
  } op_t;

  localparam logic REG_CULL_ENABLE = 1'b0;
  localparam logic REG_EDGE_BIAS   = 1'b1;

  // left, right, bottom, top, far (near is never built)
  localparam logic [1:0] PLANE_ROW [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic       PLANE_NEG [PLANE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
    logic    trunc;
  } mac_ctl_t;

  typedef enum logic {
    RD_SQRT = 1'b0,
    RD_DIV  = 1'b1
  } rd_mode_t;

  typedef struct packed {
    logic        start;
    rd_mode_t    mode;
    logic [63:0] num;
    logic [31:0] den;
  } rd_req_t;

endpackage

FILE: hw/rtl/fsc_rootdiv.sv
// Serial root / divide: one root bit (from two radicand bits) or one quotient bit per cycle.
module fsc_rootdiv (
  input  logic            clk,
  input  logic            rst,
  input  fsc_pkg::rd_req_t req,
  output logic            done,
  output logic [63:0]     result
);
  import fsc_pkg::*;

  logic [34:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [63:0] src;
  logic [31:0] den;
  rd_mode_t    mode;
  logic [5:0]  count;
  logic        running;
  logic        ge;
  logic        last;

  always_comb begin
    if (mode == RD_SQRT) begin
      rem_sh = {rem[32:0], src[63:62]};
      trial  = {1'b0, result[31:0], 2'b01};
      last   = (count == 6'd31);
    end else begin
      rem_sh = {rem[33:0], src[63]};
      trial  = {3'b000, den};
      last   = (count == 6'd63);
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= '0;
        rem     <= '0;
        result  <= '0;
        src     <= req.num;
        den     <= req.den;
        mode    <= req.mode;
      end else if (running) begin
        rem    <= ge ? (rem_sh - trial) : rem_sh;
        result <= {result[62:0], ge};
        src    <= (mode == RD_SQRT) ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
        count  <= count + 6'd1;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/fsc_mac.sv
// Shared multiply-accumulate: registered product, then a wide add.
module fsc_mac #(
  parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  fsc_pkg::mac_ctl_t   ctl,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  input  logic signed [67:0]  init,
  output logic signed [67:0]  acc
);
  import fsc_pkg::*;

  localparam logic signed [65:0] ROUND = (66'sd1 <<< FRAC_BITS) - 66'sd1;

  logic signed [65:0] prod;
  logic signed [65:0] prod_adj;
  logic signed [67:0] term;

  // truncate toward zero: bias negatives before the arithmetic shift
  assign prod_adj = prod + (prod[65] ? ROUND : 66'sd0);
  assign term     = ctl.trunc ? 68'(prod_adj >>> FRAC_BITS) : 68'(prod);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    case (ctl.acc_op)
      ACC_LOAD: acc <= init;
      ACC_ADD:  acc <= acc + term;
      default:  acc <= acc;
    endcase
  end

endmodule

FILE: hw/rtl/frustum_sphere_culler_unit.sv
// Channel   | Handshake            | Word
// ----------+----------------------+---------------------------------------------
// command   | start / busy         | operation, element_index, element_value,
//           |                      | center_x/y/z, object_radius, bound_radius,
//           |                      | no_cull
// result    | done (one cycle)     | was_test, visible
// config    | cfg_write            | cfg_index, cfg_data
//
// A word is taken on start while busy is low; every word gives one result word.
// Loads reply in the next cycle. A rebuild forms, squares, roots and normalises
// each of the five planes in turn. A test scales the radius by the largest world
// column length, forms the centre, then checks the planes; a cull ends it early.
// Roots and divides run on the serial root/divide unit (one digit a cycle).
// Sync active-high reset clears control and the plane store; config takes its defaults.
// Results cannot be stalled: done is a one-cycle strobe.
module frustum_sphere_culler_unit #(
  parameter int DATA_WIDTH = fsc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = fsc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic signed [31:0] object_radius,
  input  logic signed [31:0] bound_radius,
  input  logic               no_cull,
  output logic               done,
  output logic               was_test,
  output logic               visible,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);
  import fsc_pkg::*;

  // value width: data path capped at the 32-bit fields
  localparam int VW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [67:0] SAT_HI = (68'sd1 <<< (VW - 1)) - 68'sd1;
  localparam logic signed [67:0] SAT_LO = -SAT_HI - 68'sd1;
  // squared length threshold for 0.0001
  localparam logic [63:0] THRESH = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
  localparam logic [32:0] BIAS_RAW = 33'd3 << FRAC_BITS;
  localparam logic [30:0] BIAS_RST = (BIAS_RAW > 33'h07FFFFFFF) ? 31'h7FFFFFFF
                                                                : BIAS_RAW[30:0];

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_PADD  = 11'b000_0000_0010,  // plane word = row 3 +/- row
    S_PSQ   = 11'b000_0000_0100,  // sum of squares of xyz
    S_PROOT = 11'b000_0000_1000,  // length
    S_PDIV  = 11'b000_0001_0000,  // normalise each word
    S_PWR   = 11'b000_0010_0000,  // store plane
    S_WSQ   = 11'b000_0100_0000,  // world column squared length
    S_WROOT = 11'b000_1000_0000,  // column length, keep max
    S_RAD   = 11'b001_0000_0000,  // scaled radius
    S_WCT   = 11'b010_0000_0000,  // world centre
    S_DIST  = 11'b100_0000_0000   // plane distance test
  } state_t;

  function automatic logic signed [31:0] sat_vw(input logic signed [67:0] v);
    logic signed [67:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[31:0];
  endfunction

  state_t state;
  logic [2:0] cnt;
  logic       ph;
  logic [2:0] idx;
  logic       rd_go;

  logic        cull_enable;
  logic [30:0] edge_bias;

  logic signed [31:0] cam [16];
  logic signed [31:0] wld [12];
  logic signed [31:0] pln [20];
  logic signed [31:0] p   [4];
  logic signed [31:0] wc  [3];
  logic signed [31:0] tmp;
  logic [31:0]        len;
  logic [31:0]        scale;
  logic signed [33:0] limit;
  logic signed [31:0] cx, cy, cz, orad, brad;
  logic               use_orad;

  // shared units
  mac_ctl_t           mac_ctl;
  logic signed [32:0] mac_a, mac_b;
  logic signed [67:0] mac_init, acc;
  rd_req_t            rd_req;
  logic               rd_done;
  logic [63:0]        rd_result;

  // read ports and helpers
  logic [1:0]         term;
  logic [2:0]         last_cnt;
  logic               sop_active;
  logic [3:0]         cam_addr, wld_addr;
  logic [4:0]         pln_addr;
  logic signed [31:0] cam_rd, wld_rd, pln_rd, wc_rd, ctr_rd, p_cur;
  logic [31:0]        p_mag;
  logic signed [67:0] q_signed, add_sum;
  logic signed [31:0] in_val, in_cx, in_cy, in_cz, in_orad, in_brad, rsat;

  assign busy = (state != S_IDLE);

  assign in_val  = sat_vw(68'(element_value));
  assign in_cx   = sat_vw(68'(center_x));
  assign in_cy   = sat_vw(68'(center_y));
  assign in_cz   = sat_vw(68'(center_z));
  assign in_orad = sat_vw(68'(object_radius));
  assign in_brad = sat_vw(68'(bound_radius));

  assign term     = cnt[1:0] - 2'd1;
  assign last_cnt = (state == S_RAD) ? 3'd3 : 3'd5;
  assign rsat     = sat_vw(acc);

  assign cam_addr = ph ? {cnt[1:0], PLANE_ROW[idx]} : {cnt[1:0], 2'd3};
  assign pln_addr = {idx, (cnt == 3'd0) ? 2'd3 : term};
  assign cam_rd   = cam[cam_addr];
  assign wld_rd   = wld[wld_addr];
  assign pln_rd   = pln[pln_addr];

  always_comb begin
    case (state)
      S_WSQ:   wld_addr = (4'(idx[1:0]) << 1) + 4'(idx[1:0]) + 4'(term);
      S_WCT:   wld_addr = (use_orad || cnt == 3'd0) ? 4'd9 + 4'(idx[1:0])
                        : 4'(idx[1:0]) + (4'(term) << 1) + 4'(term);
      default: wld_addr = 4'd0;
    endcase
  end

  always_comb begin
    case (term)
      2'd0:    begin wc_rd = wc[0]; ctr_rd = cx; end
      2'd1:    begin wc_rd = wc[1]; ctr_rd = cy; end
      2'd2:    begin wc_rd = wc[2]; ctr_rd = cz; end
      default: begin wc_rd = '0;    ctr_rd = '0; end
    endcase
  end

  // normalisation divide operands
  assign p_cur    = p[cnt[1:0]];
  assign p_mag    = p_cur[31] ? 32'(-p_cur) : p_cur;
  assign q_signed = p_cur[31] ? -68'(signed'({4'b0, rd_result}))
                              : 68'(signed'({4'b0, rd_result}));
  assign add_sum  = PLANE_NEG[idx] ? 68'(tmp) - 68'(cam_rd) : 68'(tmp) + 68'(cam_rd);

  // sum-of-products sequencing: load at 0, multiply 1..n, add 2..n+1, use at n+2
  always_comb begin
    sop_active = (state inside {S_PSQ, S_WSQ, S_RAD, S_DIST}) ||
                 (state == S_WCT && !use_orad);
    mac_ctl.trunc  = (state inside {S_RAD, S_WCT, S_DIST});
    mac_ctl.mul_en = sop_active && (cnt >= 3'd1) && (cnt <= last_cnt - 3'd2);
    if (!sop_active) begin
      mac_ctl.acc_op = ACC_HOLD;
    end else if (cnt == 3'd0) begin
      mac_ctl.acc_op = ACC_LOAD;
    end else if (cnt >= 3'd2 && cnt <= last_cnt - 3'd1) begin
      mac_ctl.acc_op = ACC_ADD;
    end else begin
      mac_ctl.acc_op = ACC_HOLD;
    end
    case (state)
      S_PSQ: begin
        mac_a = 33'(p[term]); mac_b = 33'(p[term]); mac_init = '0;
      end
      S_WSQ: begin
        mac_a = 33'(wld_rd); mac_b = 33'(wld_rd); mac_init = '0;
      end
      S_RAD: begin
        mac_a = 33'(use_orad ? orad : brad); mac_b = {1'b0, scale}; mac_init = '0;
      end
      S_WCT: begin
        mac_a = 33'(wld_rd); mac_b = 33'(ctr_rd); mac_init = 68'(wld_rd);
      end
      S_DIST: begin
        mac_a = 33'(pln_rd); mac_b = 33'(wc_rd); mac_init = 68'(pln_rd);
      end
      default: begin
        mac_a = '0; mac_b = '0; mac_init = '0;
      end
    endcase
  end

  always_comb begin
    rd_req.start = !rd_go && ((state == S_PDIV) || (state == S_WROOT) ||
                              (state == S_PROOT && acc[63:0] > THRESH));
    rd_req.mode  = (state == S_PDIV) ? RD_DIV : RD_SQRT;
    rd_req.num   = (state == S_PDIV) ? (64'(p_mag) << FRAC_BITS) : acc[63:0];
    rd_req.den   = len;
  end

  fsc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  fsc_rootdiv u_rootdiv (
    .clk    (clk),
    .rst    (rst),
    .req    (rd_req),
    .done   (rd_done),
    .result (rd_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      ph          <= 1'b0;
      idx         <= '0;
      rd_go       <= 1'b0;
      cull_enable <= 1'b1;
      edge_bias   <= BIAS_RST;
      done        <= 1'b0;
      was_test    <= 1'b0;
      visible     <= 1'b0;
      for (int i = 0; i < 20; i++) begin
        pln[i] <= '0;
      end
    end else begin
      done     <= 1'b0;
      was_test <= 1'b0;
      visible  <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_CULL_ENABLE: cull_enable <= cfg_data[0];
          REG_EDGE_BIAS:   edge_bias   <= cfg_data;
          default:         ;
        endcase
      end
      case (state)
        S_IDLE: if (start) begin
          case (operation)
            OP_LOAD_CAM: begin
              cam[element_index] <= in_val;
              done <= 1'b1;
            end
            OP_LOAD_WLD: begin
              if (element_index < 4'd12) begin
                wld[element_index] <= in_val;
              end
              done <= 1'b1;
            end
            OP_BUILD: begin
              state <= S_PADD;
              idx   <= '0;
              cnt   <= '0;
              ph    <= 1'b0;
            end
            default: begin
              cx       <= in_cx;
              cy       <= in_cy;
              cz       <= in_cz;
              orad     <= in_orad;
              brad     <= in_brad;
              use_orad <= (in_orad > 32'sd0);
              if (!cull_enable || no_cull || (in_orad <= 32'sd0 && in_brad <= 32'sd0)) begin
                done     <= 1'b1;
                was_test <= 1'b1;
                visible  <= 1'b1;
              end else begin
                state <= S_WSQ;
                idx   <= '0;
                cnt   <= '0;
                scale <= '0;
              end
            end
          endcase
        end
        S_PADD: begin
          if (!ph) begin
            tmp <= cam_rd;
            ph  <= 1'b1;
          end else begin
            p[cnt[1:0]] <= sat_vw(add_sum);
            ph <= 1'b0;
            if (cnt == 3'd3) begin
              cnt   <= '0;
              state <= S_PSQ;
            end else begin
              cnt <= cnt + 3'd1;
            end
          end
        end
        S_PSQ: begin
          if (cnt == last_cnt) begin
            cnt   <= '0;
            state <= S_PROOT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_PROOT: begin
          if (!rd_go) begin
            if (acc[63:0] <= THRESH) begin
              state <= S_PWR;  // tiny plane: kept as is
            end else begin
              rd_go <= 1'b1;
            end
          end else if (rd_done) begin
            rd_go <= 1'b0;
            len   <= rd_result[31:0];
            cnt   <= '0;
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (!rd_go) begin
            rd_go <= 1'b1;
          end else if (rd_done) begin
            rd_go       <= 1'b0;
            p[cnt[1:0]] <= sat_vw(q_signed);
            if (cnt == 3'd3) begin
              cnt   <= '0;
              state <= S_PWR;
            end else begin
              cnt <= cnt + 3'd1;
            end
          end
        end
        S_PWR: begin
          for (int j = 0; j < 4; j++) begin
            pln[{idx, 2'(j)}] <= p[j];
          end
          if (idx == 3'(PLANE_COUNT - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + 3'd1;
            cnt   <= '0;
            ph    <= 1'b0;
            state <= S_PADD;
          end
        end
        S_WSQ: begin
          if (cnt == last_cnt) begin
            cnt   <= '0;
            state <= S_WROOT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_WROOT: begin
          if (!rd_go) begin
            rd_go <= 1'b1;
          end else if (rd_done) begin
            rd_go <= 1'b0;
            if (rd_result[31:0] > scale) begin
              scale <= rd_result[31:0];
            end
            cnt <= '0;
            if (idx == 3'd2) begin
              idx   <= '0;
              state <= S_RAD;
            end else begin
              idx   <= idx + 3'd1;
              state <= S_WSQ;
            end
          end
        end
        S_RAD: begin
          if (cnt == last_cnt) begin
            cnt <= '0;
            if (rsat <= 32'sd0) begin
              done     <= 1'b1;
              was_test <= 1'b1;
              visible  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              limit <= -(34'(rsat) + 34'({3'b000, edge_bias}));
              idx   <= '0;
              state <= S_WCT;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_WCT: begin
          if (use_orad || cnt == last_cnt) begin
            wc[idx[1:0]] <= use_orad ? wld_rd : sat_vw(acc);
            cnt <= '0;
            if (idx == 3'd2) begin
              idx   <= '0;
              state <= S_DIST;
            end else begin
              idx <= idx + 3'd1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_DIST: begin
          if (cnt == last_cnt) begin
            cnt <= '0;
            if (acc < 68'(limit)) begin
              done     <= 1'b1;
              was_test <= 1'b1;
              state    <= S_IDLE;
            end else if (idx == 3'(PLANE_COUNT - 1)) begin
              done     <= 1'b1;
              was_test <= 1'b1;
              visible  <= 1'b1;
              state    <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/fsc_checker.sv
`include "assert_macros.svh"

module fsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       done,
  input logic       was_test,
  input logic       visible
);
  import fsc_pkg::*;

  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLY(a_visible_test, clk, rst, visible, done && was_test)
  `ASSERT_NEXT(a_load_reply, clk, rst, start && !busy && (operation == OP_LOAD_CAM || operation == OP_LOAD_WLD), done && !was_test)
  `ASSERT_IMPLY(a_busy_origin, clk, rst, $rose(busy), $past(start))
  `ASSERT_IMPLY(a_done_origin, clk, rst, done, $past(busy) || $past(start))

endmodule

bind frustum_sphere_culler_unit fsc_checker u_fsc_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .was_test  (was_test),
  .visible   (visible)
);
